// ===== rtl/core/sieve_cache_replacement_macros.svh =====
// assertion macros for the sieve cache replacement block
// depends on nothing; taken in by the top level with an include
`ifndef SIEVE_CACHE_REPLACEMENT_MACROS_SVH
`define SIEVE_CACHE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off during reset
`define SCR_ASSERT_IMP(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error("scr implication check failed");

// next-cycle implication, held off during reset
`define SCR_ASSERT_NXT(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error("scr next-cycle check failed");

`else

`define SCR_ASSERT_IMP(name, clock, resetn, pre, post)
`define SCR_ASSERT_NXT(name, clock, resetn, pre, post)

`endif

`endif

// ===== rtl/core/scr_pkg.sv =====
// shared types and constants of the sieve cache replacement block
// used by scr_cell, scr_victim and the top level; depends on nothing
`timescale 1ns / 1ps

package scr_pkg;

    // stream payload widths
    localparam int ACCESS_KEY_W = 32;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 40;
    localparam int OUT_KEY_W    = 32;
    localparam int WIDE_KEY_W   = 64;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // request sequencing
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // per-cell control from the top level
    typedef struct packed {
        logic capture;
        logic insert;
        logic shift;
        logic set_visited;
        logic clear_visited;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/sieve_cache_replacement.sv =====
// sieve cache replacement: request sequencing, cell row, hand and output register
// depends on scr_pkg, scr_cell, scr_victim and sieve_cache_replacement_macros.svh
`timescale 1ns / 1ps
`include "sieve_cache_replacement_macros.svh"

// Usage
// Requests come in on s_tvalid/s_tready/s_tdata (the access key). Each request
// yields one result on m_tvalid/m_tready/m_tdata: hit flag, eviction flag and
// the evicted key (zero unless an entry was evicted).
// Entries live in a row of cells, tail at cell 0 and newest above it; every
// cell compares its key, and on an eviction the cells from the victim up take
// their newer neighbor's entries. A request is held in the key register, then
// compared into the cells' match registers, then used for victim search, row
// update and result register load; the next request is taken with that update.
// The capacity register (APB, address 0) must be written only while idle;
// the block does not enforce it. Reset empties the cache, drops the hand and
// sets capacity to 16; no clearing pass is needed, so requests are taken right
// after reset. A stalled receiver holds the result in the output register; one
// more request may be taken and compared, then the update waits for m_tready.

module sieve_cache_replacement import scr_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] access_key
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] hit, [1] evicted, [33:2] evicted_key
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int N    = MAX_ENTRIES;
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int OW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

    state_t state_reg;
    state_t state_next;

    logic [CAP_W-1:0]    capacity_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [OW-1:0]       occ_reg;
    logic [OW-1:0]       occ_next;
    logic                hand_valid_reg;
    logic                hand_valid_next;
    logic [IW-1:0]       hand_pos_reg;
    logic [IW-1:0]       hand_pos_next;
    logic                m_valid_reg;
    logic                res_hit_reg;
    logic                res_evicted_reg;
    logic [OUT_KEY_W-1:0] res_key_reg;

    logic                  accept;
    logic                  upd_go;
    logic                  upd_en;
    logic                  capture;
    logic [WIDE_KEY_W-1:0] in_wide;
    logic [KEY_BITS-1:0]   in_key;
    logic                  cfg_write;

    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] eff_cap;
    logic            full;
    logic            hit;
    logic            evict;
    logic [IW-1:0]   start_idx;
    logic [OW-1:0]   ins_pos;

    logic [KEY_BITS-1:0] cell_key [N];
    logic [N-1:0]        cell_visited;
    logic [N-1:0]        cell_visited_fwd;
    logic [N-1:0]        cell_match;
    cell_ctrl_t          cell_ctrl [N];

    logic [N-1:0]  valid;
    logic [N-1:0]  ge_start;
    logic [N-1:0]  start_oh;
    logic [N-1:0]  ins_sel;
    logic [N-1:0]  hit_vec;
    logic [N-1:0]  hit_oh;
    logic [N-1:0]  victim_oh;
    logic [N-1:0]  clear_mask;
    logic [N-1:0]  shift_mask;
    logic [IW-1:0] victim_idx;

    logic [KEY_BITS-1:0]   victim_key;
    logic [WIDE_KEY_W-1:0] victim_wide;

    // input key masked to the stored width
    assign in_wide = {{(WIDE_KEY_W - ACCESS_KEY_W){1'b0}}, s_tdata[ACCESS_KEY_W-1:0]};
    assign in_key  = in_wide[KEY_BITS-1:0];
    assign accept  = s_tvalid & s_tready;
    assign upd_go  = ~m_valid_reg | m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = s_tvalid ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        upd_en   = 1'b0;
        capture  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_CMP:
            begin
                capture = 1'b1;
            end
            ST_UPD:
            begin
                s_tready = upd_go;
                upd_en   = upd_go;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // effective capacity: zero acts as one, clipped at the row length
    always_comb
    begin
        cap_ext = CMPW'(capacity_reg);
        priority if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(MAX_ENTRIES))
        begin
            eff_cap = CMPW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    // hit detection, oldest match counts
    always_comb
    begin
        hit_vec = cell_match & valid;
        hit_oh  = hit_vec & (~hit_vec + N'(1));
        hit     = (hit_vec != '0);
        full    = (CMPW'(occ_reg) >= eff_cap) && (occ_reg != '0);
        evict   = ~hit & full;
        // a hand past the occupied part acts as no hand
        start_idx = (hand_valid_reg && (OW'(hand_pos_reg) < occ_reg)) ? hand_pos_reg : '0;
        ins_pos   = evict ? (occ_reg - OW'(1)) : occ_reg;
    end

    // per-cell position decodes and controls
    for (genvar i = 0; i < N; i++)
    begin : g_ctrl
        localparam logic [IW-1:0] IDX_I = IW'(i);
        localparam logic [OW-1:0] IDX_O = OW'(i);

        assign valid[i]    = IDX_O < occ_reg;
        assign ge_start[i] = IDX_I >= start_idx;
        assign start_oh[i] = IDX_I == start_idx;
        assign ins_sel[i]  = IDX_O == ins_pos;

        assign cell_ctrl[i].capture       = capture;
        assign cell_ctrl[i].insert        = upd_en & ~hit & ins_sel[i];
        assign cell_ctrl[i].shift         = upd_en & evict & shift_mask[i];
        assign cell_ctrl[i].set_visited   = upd_en & hit & hit_oh[i];
        assign cell_ctrl[i].clear_visited = upd_en & evict & clear_mask[i];
    end

    // row of entry cells, each fed by its newer neighbor
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] nbr_key;
        logic                nbr_visited;

        if (i < N - 1)
        begin : g_mid
            assign nbr_key     = cell_key[i+1];
            assign nbr_visited = cell_visited_fwd[i+1];
        end
        else
        begin : g_end
            assign nbr_key     = '0;
            assign nbr_visited = 1'b0;
        end

        scr_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[i]),
            .lookup_key  (key_reg),
            .new_key     (key_reg),
            .nbr_key     (nbr_key),
            .nbr_visited (nbr_visited),
            .key         (cell_key[i]),
            .visited     (cell_visited[i]),
            .visited_fwd (cell_visited_fwd[i]),
            .match       (cell_match[i])
        );
    end

    // victim search
    scr_victim #(
        .N  (N),
        .IW (IW)
    ) u_victim (
        .valid      (valid),
        .visited    (cell_visited),
        .ge_start   (ge_start),
        .start_oh   (start_oh),
        .victim_oh  (victim_oh),
        .clear_mask (clear_mask),
        .shift_mask (shift_mask),
        .victim_idx (victim_idx)
    );

    // evicted key select, widened then cut to the output field
    always_comb
    begin
        victim_key  = '0;
        victim_wide = '0;
        for (int i = 0; i < N; i++)
        begin
            if (victim_oh[i])
            begin
                victim_key = victim_key | cell_key[i];
            end
        end
        victim_wide[KEY_BITS-1:0] = victim_key;
    end

    // occupancy and hand
    always_comb
    begin
        occ_next        = occ_reg;
        hand_valid_next = hand_valid_reg;
        hand_pos_next   = hand_pos_reg;
        if (upd_en && !hit)
        begin
            if (evict)
            begin
                if ((OW'(victim_idx) + OW'(1)) < occ_reg)
                begin
                    hand_valid_next = 1'b1;
                    hand_pos_next   = victim_idx;
                end
                else
                begin
                    hand_valid_next = 1'b0;
                    hand_pos_next   = '0;
                end
            end
            else
            begin
                occ_next = occ_reg + OW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            hand_valid_reg <= 1'b0;
            hand_pos_reg   <= '0;
            m_valid_reg    <= 1'b0;
            capacity_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            hand_valid_reg <= hand_valid_next;
            hand_pos_reg   <= hand_pos_next;
            if (upd_en)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    // request key and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
        end
        if (upd_en)
        begin
            res_hit_reg     <= hit;
            res_evicted_reg <= evict;
            res_key_reg     <= evict ? victim_wide[OUT_KEY_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_KEY_W - 2){1'b0}}, res_key_reg,
                       res_evicted_reg, res_hit_reg};

    // configuration port
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    // checks
    `SCR_ASSERT_IMP(a_victim_onehot, clk, rst_n, upd_en && evict, $onehot(victim_oh))
    `SCR_ASSERT_NXT(a_evict_keeps_occ, clk, rst_n, upd_en && evict, $stable(occ_reg))
    `SCR_ASSERT_IMP(a_hand_in_range, clk, rst_n, hand_valid_reg, OW'(hand_pos_reg) < occ_reg)
    `SCR_ASSERT_NXT(a_accept_to_cmp, clk, rst_n, accept, state_reg == ST_CMP)

endmodule

// ===== rtl/core/scr_cell.sv =====
// one cache entry cell: key, visited bit and registered key compare
// depends on scr_pkg; instanced in a row by the top level
`timescale 1ns / 1ps

module scr_cell import scr_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] lookup_key,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [KEY_BITS-1:0] nbr_key,
    input  logic                nbr_visited,
    output logic [KEY_BITS-1:0] key,
    output logic                visited,
    output logic                visited_fwd,
    output logic                match
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                visited_reg;
    logic                visited_next;
    logic                match_reg;

    // visited bit after this request's sweep clears it
    assign visited_fwd = visited_reg & ~ctrl.clear_visited;

    // new entry beats a shift from the newer neighbor
    always_comb
    begin
        key_next     = key_reg;
        visited_next = visited_fwd | ctrl.set_visited;
        priority if (ctrl.insert)
        begin
            key_next     = new_key;
            visited_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            key_next     = nbr_key;
            visited_next = nbr_visited;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctrl.capture)
        begin
            match_reg <= (key_reg == lookup_key);
        end
    end

    // visited bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    assign key     = key_reg;
    assign visited = visited_reg;
    assign match   = match_reg;

endmodule

// ===== rtl/core/scr_victim.sv =====
// victim search over the cell row: first unvisited entry from the hand
// depends on scr_pkg; instanced by the top level
`timescale 1ns / 1ps

module scr_victim import scr_pkg::*;
#(
    parameter int N  = 16,
    parameter int IW = 4
)
(
    input  logic [N-1:0]  valid,
    input  logic [N-1:0]  visited,
    input  logic [N-1:0]  ge_start,
    input  logic [N-1:0]  start_oh,
    output logic [N-1:0]  victim_oh,
    output logic [N-1:0]  clear_mask,
    output logic [N-1:0]  shift_mask,
    output logic [IW-1:0] victim_idx
);

    logic [N-1:0] unvis;
    logic [N-1:0] cand_hi;
    logic [N-1:0] low_hi;
    logic [N-1:0] low_all;

    // lowest set bit of the candidates at or above the hand, and of all
    always_comb
    begin
        unvis   = valid & ~visited;
        cand_hi = unvis & ge_start;
        low_hi  = cand_hi & (~cand_hi + N'(1));
        low_all = unvis & (~unvis + N'(1));
    end

    // victim and the visited bits the walk clears on its way
    always_comb
    begin
        priority if (cand_hi != '0)
        begin
            victim_oh  = low_hi;
            clear_mask = ge_start & (low_hi - N'(1));
        end
        else if (unvis != '0)
        begin
            // walk wraps from head to tail
            victim_oh  = low_all;
            clear_mask = (ge_start & valid) | (low_all - N'(1));
        end
        else
        begin
            // everything visited: full lap, the start entry goes
            victim_oh  = start_oh;
            clear_mask = valid;
        end
        shift_mask = ~(victim_oh - N'(1));
    end

    // one-hot to index
    always_comb
    begin
        victim_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (victim_oh[i])
            begin
                victim_idx = victim_idx | IW'(i);
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the sieve cache replacement block
// drives access requests and capacity writes, predicts hit/eviction results in step
// depends on scr_pkg and the sieve_cache_replacement top level
`timescale 1ns / 1ps

module tb;
    import scr_pkg::*;

    localparam int CACHE_SLOTS = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES = 200;
    localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct {
        logic        hit;
        logic        evicted;
        logic [31:0] evicted_key;
    } outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] access_key
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] hit, [1] evicted, [33:2] evicted_key
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // predicted cache contents, tail at slot 0
    logic [31:0]   cache_key [CACHE_SLOTS];
    logic          cache_visited [CACHE_SLOTS];
    int unsigned   cache_fill;
    logic          hand_valid;
    int unsigned   hand_pos;
    logic [4:0]    capacity_reg;

    outcome_t      pending_outcomes [$];
    logic [31:0]   key_pool [$];
    int            errors;
    logic          send_idle;
    logic          recv_idle;
    int unsigned   sink_gap;
    int unsigned   hold_request;

    sieve_cache_replacement dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #5 clk = ~clk;

    // sieve policy: lookup, victim walk from the hand, insert at the head
    function automatic outcome_t predict_access(input logic [31:0] key);
        outcome_t    res;
        int unsigned cap_eff;
        int unsigned pos;
        int unsigned i;
        logic        found;
        res.hit = 1'b0;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        found = 1'b0;
        for (i = 0; i < cache_fill; i++)
        begin
            if (!found && cache_key[i] == key)
            begin
                cache_visited[i] = 1'b1;
                found = 1'b1;
            end
        end
        if (found)
        begin
            res.hit = 1'b1;
            return res;
        end
        if (capacity_reg == 0)
            cap_eff = 1;
        else if (capacity_reg > CACHE_SLOTS)
            cap_eff = CACHE_SLOTS;
        else
            cap_eff = 32'(capacity_reg);
        // evict: clear visited bits until an unvisited entry turns up
        if (cache_fill >= cap_eff && cache_fill > 0)
        begin
            pos = (hand_valid && hand_pos < cache_fill) ? hand_pos : 0;
            while (cache_visited[pos])
            begin
                cache_visited[pos] = 1'b0;
                pos++;
                if (pos >= cache_fill)
                    pos = 0;
            end
            res.evicted = 1'b1;
            res.evicted_key = cache_key[pos];
            hand_valid = (pos + 1 < cache_fill);
            hand_pos = hand_valid ? pos : 0;
            for (i = pos; i + 1 < cache_fill; i++)
            begin
                cache_key[i] = cache_key[i + 1];
                cache_visited[i] = cache_visited[i + 1];
            end
            cache_fill--;
        end
        if (cache_fill < CACHE_SLOTS)
        begin
            cache_key[cache_fill] = key;
            cache_visited[cache_fill] = 1'b0;
            cache_fill++;
        end
        return res;
    endfunction

    // offer one request, predict its result once it is taken
    task automatic send_access(input logic [31:0] key);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= key;
        do
            @(posedge clk);
        while (!s_tready);
        pending_outcomes.push_back(predict_access(key));
    endtask

    // stop offering and let every result come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // capacity register write, upper data bits random
    task automatic write_capacity(input logic [4:0] value);
        logic [31:0] word;
        word = $urandom();
        word[4:0] = value;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        capacity_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // working set larger than the effective capacity by one up to that capacity plus one
    task automatic fill_pool(input logic [4:0] cap);
        int unsigned cap_eff;
        int unsigned n;
        cap_eff = (cap == 0) ? 1 : ((cap > CACHE_SLOTS) ? CACHE_SLOTS : 32'(cap));
        n = cap_eff + $urandom_range(1, cap_eff + 1);
        key_pool.delete();
        repeat (n) key_pool.push_back($urandom());
    endtask

    function automatic logic [31:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (roll < 95)
            return $urandom();
        else
            return (roll[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    task automatic run_phase(input logic [4:0] cap, input int unsigned count);
        wait_drained();
        write_capacity(cap);
        fill_pool(cap);
        repeat (count) send_access(pick_key());
    endtask

    // extreme keys, hits, walk with wrap, head eviction, out-of-range capacities
    task automatic test_directed();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        wait_drained();
        write_capacity(5'd2);
        send_access(32'h1234_5678);
        send_access(32'hFFFF_FFFF);
        send_access(32'hA5A5_5A5A);
        send_access(32'h5A5A_A5A5);
        send_access(32'hA5A5_5A5A);
        // zero acts as one, below current occupancy
        wait_drained();
        write_capacity(5'd0);
        send_access(32'h8000_0001);
        send_access(32'h8000_0001);
        send_access(32'h7FFF_FFFE);
        // above the slot count acts as the slot count
        wait_drained();
        write_capacity(5'd31);
        send_access(32'hDEAD_BEEF);
        send_access(32'h0F0F_0F0F);
        send_access(32'h7FFF_FFFE);
        send_access(32'hF0F0_F0F0);
        wait_drained();
        write_capacity(5'd3);
        send_access(32'h0000_0001);
        send_access(32'hDEAD_BEEF);
        send_access(32'h0000_0002);
        send_access(32'h0000_0003);
    endtask

    // short runs at the capacity extremes and a few in between
    task automatic test_capacity_sweep();
        logic [4:0] caps [8];
        int unsigned k;
        caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd15, 5'd8};
        for (k = 0; k < 8; k++)
        begin
            send_idle = 1'($urandom_range(0, 1));
            recv_idle = 1'($urandom_range(0, 1));
            run_phase(caps[k], 25);
        end
    endtask

    // long random runs with random capacity and idling
    task automatic test_random_traffic();
        logic [4:0] cap;
        repeat (12)
        begin
            cap = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
            send_idle = $urandom_range(0, 2) != 0;
            recv_idle = $urandom_range(0, 2) != 0;
            run_phase(cap, 110);
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        wait_drained();
        write_capacity(5'd4);
        fill_pool(5'd4);
        send_access(pick_key());
        hold_request = HOLD_CYCLES;
        repeat (30) send_access(pick_key());
    endtask

    // result sink: per-result stall plus the long hold
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (sink_gap != 0)
            begin
                m_tready <= 1'b0;
                sink_gap--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tdata[0] !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.evicted)
                begin
                    $display("%0t: evicted expected %b actual %b",
                             $time, want.evicted, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[33:2] !== want.evicted_key)
                begin
                    $display("%0t: evicted_key expected %h actual %h",
                             $time, want.evicted_key, m_tdata[33:2]);
                    errors++;
                end
            end
            sink_gap = recv_idle ? $urandom_range(0, 7) : 0;
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // reset, then the tests in turn
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        sink_gap = 0;
        hold_request = 0;
        cache_fill = 0;
        hand_valid = 1'b0;
        hand_pos = 0;
        capacity_reg = CAP_RESET;
        foreach (cache_visited[i])
        begin
            cache_visited[i] = 1'b0;
            cache_key[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_capacity_sweep();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
